@@ sv/anchor_prefilter_match_counter_defines.svh @@
// Assertion macros shared by the checker of the match counter.
// Depends on a clk_i and an rst_ni signal in the scope of each use.
`ifndef ANCHOR_PREFILTER_MATCH_COUNTER_DEFINES_SVH
`define ANCHOR_PREFILTER_MATCH_COUNTER_DEFINES_SVH

// Checked at every rising edge, suspended while reset is asserted.
`define APMC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked at every rising edge, also during reset.
`define APMC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

@@ sv/apmc_pkg.sv @@
// Package of the anchor prefilter match counter: item codes, needle size,
// reset length and the anchor scatter table. No dependencies.
package apmc_pkg;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_CORPUS = 2'd1,
    OP_END    = 2'd2
  } op_e;

  localparam int unsigned NEEDLE_MAX   = 16;
  localparam int unsigned ANCHOR_COUNT = 4;
  localparam logic [4:0]  LEN_RESET    = 5'd4;

  // (slot * 7) mod cell for cell values 0 to 7; zero where the cell is 0 or 1.
  localparam logic [2:0] SCATTER_TAB [ANCHOR_COUNT][8] = '{
    '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
    '{3'd0, 3'd0, 3'd1, 3'd1, 3'd3, 3'd2, 3'd1, 3'd0},
    '{3'd0, 3'd0, 3'd0, 3'd2, 3'd2, 3'd4, 3'd2, 3'd0},
    '{3'd0, 3'd0, 3'd1, 3'd0, 3'd1, 3'd1, 3'd3, 3'd0}
  };

endpackage

@@ sv/anchor_prefilter_match_counter.sv @@
// Top level of the anchor prefilter match counter.
// Depends on apmc_pkg for item codes, the needle size, the reset length and the scatter table.

// One transaction is accepted per clock cycle while the output does not stall, and
// its result is presented from a result register: the item sits in an input register,
// the shifted window is compared against the needle at all positions in parallel, and
// the flags and count land in the result register, which holds while the output stalls.
// The input register advances whenever the result register is empty or being taken, so
// the sustained rate is one item per cycle while the output does not stall. A length write
// clamps the length to 1..NEEDLE_MAX and recomputes the four anchor offsets
// in the same cycle; the configuration port is always ready.
module anchor_prefilter_match_counter import apmc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [7:0]  byte_value_i,
  input  logic [3:0]  needle_index_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [4:0]  cfg_needle_len_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        anchors_agree_o,
  output logic        match_here_o,
  output logic [31:0] occurrences_o,
  output logic        done_res_o
);

  localparam int unsigned LEN_W = $clog2(NEEDLE_MAX + 1);
  localparam int unsigned IDX_W = $clog2(NEEDLE_MAX);
  localparam int unsigned WIN_W = NEEDLE_MAX * 8;

  function automatic logic [LEN_W-1:0] eff_len(input logic [4:0] value);
    logic [7:0] v;
    v = 8'(value);
    if (v == 8'd0) v = 8'd1;
    if (v > 8'(NEEDLE_MAX)) v = 8'(NEEDLE_MAX);
    return LEN_W'(v);
  endfunction

  function automatic logic [IDX_W-1:0] off_calc(input logic [LEN_W-1:0] len,
                                                input int unsigned slot);
    logic [2:0] span;
    logic [7:0] off;
    logic [7:0] lim;
    span = 3'(len >> 2);
    off  = 8'(slot) * 8'(span) + 8'(SCATTER_TAB[slot][span]);
    lim  = 8'(len) - 8'd1;
    return IDX_W'((off >= lim) ? lim : off);
  endfunction

  logic             s1_valid_q;
  logic [1:0]       s1_op_q;
  logic [7:0]       s1_byte_q;
  logic [3:0]       s1_idx_q;
  logic             out_valid_q;
  logic             agree_q;
  logic             match_q;
  logic [31:0]      occ_q;
  logic             done_q;
  logic [LEN_W-1:0] len_q;
  logic [IDX_W-1:0] offs_q [ANCHOR_COUNT];
  logic [WIN_W-1:0] win_q;
  logic [LEN_W-1:0] fill_q;
  logic [31:0]      count_q;
  logic [7:0]       needle_q [NEEDLE_MAX];

  logic             advance;
  logic             in_fire;
  logic [WIN_W-1:0] win_shift;
  logic [WIN_W-1:0] win_rev;
  logic [WIN_W-1:0] aligned;
  logic [LEN_W-1:0] shift_amt;
  logic [LEN_W-1:0] fill_inc;
  logic [NEEDLE_MAX-1:0] eq;
  logic             full;
  logic             agree_all;
  logic             is_corpus;
  logic             corpus_hit;
  logic [31:0]      count_inc;

  assign advance     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || advance;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    win_shift = {win_q[WIN_W-9:0], s1_byte_q};
    for (int k = 0; k < NEEDLE_MAX; k++) begin
      win_rev[8*k +: 8] = win_shift[8*(NEEDLE_MAX-1-k) +: 8];
    end
    shift_amt = LEN_W'(NEEDLE_MAX) - len_q;
    aligned   = win_rev >> {shift_amt, 3'b000};
    for (int p = 0; p < NEEDLE_MAX; p++) begin
      eq[p] = (aligned[8*p +: 8] == needle_q[p]) || (LEN_W'(p) >= len_q);
    end
    agree_all = 1'b1;
    for (int s = 0; s < ANCHOR_COUNT; s++) begin
      agree_all = agree_all && eq[offs_q[s]];
    end
    fill_inc   = (fill_q < LEN_W'(NEEDLE_MAX)) ? fill_q + LEN_W'(1) : fill_q;
    full       = fill_inc >= len_q;
    is_corpus  = s1_op_q == OP_CORPUS;
    corpus_hit = is_corpus && full && (&eq);
    count_inc  = (corpus_hit && count_q != '1) ? count_q + 32'd1 : count_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      len_q       <= eff_len(LEN_RESET);
      for (int s = 0; s < ANCHOR_COUNT; s++) begin
        offs_q[s] <= off_calc(eff_len(LEN_RESET), s);
      end
      win_q       <= '0;
      fill_q      <= '0;
      count_q     <= '0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        len_q <= eff_len(cfg_needle_len_i);
        for (int s = 0; s < ANCHOR_COUNT; s++) begin
          offs_q[s] <= off_calc(eff_len(cfg_needle_len_i), s);
        end
      end
      if (advance) begin
        case (s1_op_q)
          OP_CORPUS: begin
            win_q   <= win_shift;
            fill_q  <= fill_inc;
            count_q <= count_inc;
          end
          OP_END: begin
            win_q   <= '0;
            fill_q  <= '0;
            count_q <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_op_q   <= op_i;
      s1_byte_q <= byte_value_i;
      s1_idx_q  <= needle_index_i;
    end
    if (advance) begin
      agree_q <= is_corpus && full && agree_all;
      match_q <= corpus_hit;
      occ_q   <= count_inc;
      done_q  <= s1_op_q == OP_END;
      for (int k = 0; k < NEEDLE_MAX; k++) begin
        if (s1_op_q == OP_LOAD && 32'(s1_idx_q) == k) begin
          needle_q[k] <= s1_byte_q;
        end
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign anchors_agree_o = agree_q;
  assign match_here_o    = match_q;
  assign occurrences_o   = occ_q;
  assign done_res_o      = done_q;

endmodule

@@ sv/apmc_checker.sv @@
// Port-level checker of the anchor prefilter match counter and its bind.
// Depends on anchor_prefilter_match_counter_defines.svh for the macros.
`include "anchor_prefilter_match_counter_defines.svh"

module apmc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        anchors_agree_o,
  input logic        match_here_o,
  input logic [31:0] occurrences_o,
  input logic        done_res_o
);

  `APMC_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(occurrences_o) && $stable(done_res_o), "stalled result transaction changed")
  `APMC_ASSERT(a_match_implies_agree, out_valid_o && match_here_o |-> anchors_agree_o, "full match without anchor agreement")
  `APMC_ASSERT(a_done_no_flags, out_valid_o && done_res_o |-> !match_here_o && !anchors_agree_o, "end transaction carries match flags")
  `APMC_ASSERT(a_match_counted, out_valid_o && match_here_o |-> occurrences_o != 32'd0, "full match with zero count")
  `APMC_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !out_valid_o, "result valid during reset")

endmodule

bind anchor_prefilter_match_counter apmc_checker u_apmc_checker (.*);

@@ bench/anchor_prefilter_match_counter_tb.sv @@
// Self-checking testbench of anchor_prefilter_match_counter: a directed table, then random
// needle loads, planted corpus sequences and end items under varying handshake pressure.
// Depends on apmc_pkg and on the RTL of the block.
`timescale 1ns / 1ps

module anchor_prefilter_match_counter_tb import apmc_pkg::*; ();

  localparam int unsigned SCATTER_STEP = 7;
  localparam logic [1:0]  OP_UNUSED    = 2'd3;
  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          PHASE_ITEMS  = 125;
  localparam int          SEND_IDLE [4] = '{0, 53, 0, 35};
  localparam int          RECV_STALL [4] = '{0, 0, 53, 35};
  localparam logic [4:0]  PHASE_LEN [8] = '{5'd16, 5'd31, 5'd0, 5'd7, 5'd17, 5'd1, 5'd12, 5'd4};

  typedef struct packed {
    logic        anchors_ok;
    logic        full_hit;
    logic [31:0] count;
    logic        done;
  } match_res_t;

  typedef struct packed {
    logic       is_cfg;
    logic [4:0] len;
    logic [1:0] op;
    logic [7:0] data;
    logic [3:0] idx;
    logic       typed;
    match_res_t res;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  op_i;
  logic [7:0]  byte_value_i;
  logic [3:0]  needle_index_i;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [4:0]  cfg_needle_len_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        anchors_agree_o;
  logic        match_here_o;
  logic [31:0] occurrences_o;
  logic        done_res_o;

  logic [4:0]  len_reg;
  logic [7:0]  needle_mem [NEEDLE_MAX];
  int unsigned anchor_pos [ANCHOR_COUNT];
  logic [7:0]  window_mem [NEEDLE_MAX];
  int unsigned fill_level;
  logic [31:0] hit_count;

  match_res_t  pending [$];
  row_t        plan [$];
  int          error_count;
  int          items_sent;
  int          cycle_count;
  int          send_idle_pct;
  int          recv_stall_pct;
  bit          pair_mode;
  logic [7:0]  sym_a;
  logic [7:0]  sym_b;

  anchor_prefilter_match_counter u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .op_i             (op_i),
    .byte_value_i     (byte_value_i),
    .needle_index_i   (needle_index_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_needle_len_i (cfg_needle_len_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .anchors_agree_o  (anchors_agree_o),
    .match_here_o     (match_here_o),
    .occurrences_o    (occurrences_o),
    .done_res_o       (done_res_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic int unsigned active_len();
    int unsigned n;
    n = len_reg;
    if (n < 1) n = 1;
    if (n > NEEDLE_MAX) n = NEEDLE_MAX;
    return n;
  endfunction

  function automatic void derive_anchors();
    int unsigned n;
    int unsigned span;
    int unsigned off;
    n = active_len();
    span = n / ANCHOR_COUNT;
    for (int s = 0; s < ANCHOR_COUNT; s++) begin
      off = s * span + ((span > 1) ? (s * SCATTER_STEP) % span : 0);
      if (off >= n) off = n - 1;
      anchor_pos[s] = off;
    end
  endfunction

  function automatic match_res_t predict_item(input logic [1:0] op, input logic [7:0] data,
                                              input logic [3:0] idx);
    match_res_t  r;
    int unsigned n;
    r = '0;
    r.count = hit_count;
    case (op)
      OP_LOAD: begin
        needle_mem[idx] = data;
      end
      OP_CORPUS: begin
        n = active_len();
        for (int i = NEEDLE_MAX - 1; i > 0; i--) window_mem[i] = window_mem[i - 1];
        window_mem[0] = data;
        if (fill_level < NEEDLE_MAX) fill_level++;
        if (fill_level >= n) begin
          r.anchors_ok = 1'b1;
          for (int s = 0; s < ANCHOR_COUNT; s++) begin
            if (window_mem[n - 1 - anchor_pos[s]] != needle_mem[anchor_pos[s]]) begin
              r.anchors_ok = 1'b0;
            end
          end
          r.full_hit = 1'b1;
          for (int p = 0; p < n; p++) begin
            if (window_mem[n - 1 - p] != needle_mem[p]) r.full_hit = 1'b0;
          end
          if (r.full_hit && hit_count != '1) hit_count++;
        end
        r.count = hit_count;
      end
      OP_END: begin
        r.done = 1'b1;
        for (int i = 0; i < NEEDLE_MAX; i++) window_mem[i] = '0;
        fill_level = 0;
        hit_count = '0;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic logic [7:0] next_symbol();
    if (pair_mode) return $urandom_range(1) ? sym_a : sym_b;
    return 8'($urandom);
  endfunction

  function automatic void add_len(input logic [4:0] len);
    row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.len = len;
    plan.push_back(r);
  endfunction

  function automatic void add_item(input logic [1:0] op, input logic [7:0] data,
                                   input logic [3:0] idx, input logic typed,
                                   input logic agree, input logic hit,
                                   input logic [31:0] count, input logic done);
    row_t r;
    r = '0;
    r.op = op;
    r.data = data;
    r.idx = idx;
    r.typed = typed;
    r.res = '{anchors_ok: agree, full_hit: hit, count: count, done: done};
    plan.push_back(r);
  endfunction

  task automatic send_item(input logic [1:0] op, input logic [7:0] data,
                           input logic [3:0] idx, input logic use_given,
                           input match_res_t given);
    match_res_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    op_i           <= op;
    byte_value_i   <= data;
    needle_index_i <= idx;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = predict_item(op, data, idx);
    pending.push_back(use_given ? given : predicted);
    items_sent++;
  endtask

  task automatic write_len(input logic [4:0] len);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending.size() != 0);
    cfg_valid_i      <= 1'b1;
    cfg_needle_len_i <= len;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    len_reg = len;
    derive_anchors();
  endtask

  task automatic run_phase(input int phase, input logic [4:0] len);
    int unsigned n;
    int          stop_at;
    int          pick;
    send_idle_pct  = SEND_IDLE[phase % 4];
    recv_stall_pct = RECV_STALL[phase % 4];
    write_len(len);
    pair_mode = $urandom_range(1);
    sym_a = 8'($urandom);
    sym_b = 8'($urandom);
    if (phase == 0 || $urandom_range(1)) begin
      for (int i = 0; i < NEEDLE_MAX; i++) send_item(OP_LOAD, next_symbol(), 4'(i), 1'b0, '0);
    end
    n = active_len();
    stop_at = items_sent + PHASE_ITEMS;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        repeat ($urandom_range(2)) send_item(OP_CORPUS, next_symbol(), 4'($urandom), 1'b0, '0);
        for (int p = 0; p < n; p++) begin
          send_item(OP_CORPUS, ($urandom_range(99) < 6) ? 8'($urandom) : needle_mem[p],
                    4'($urandom), 1'b0, '0);
        end
      end else if (pick < 78) begin
        send_item(OP_END, 8'($urandom), 4'($urandom), 1'b0, '0);
      end else if (pick < 88) begin
        send_item(OP_LOAD, next_symbol(), 4'($urandom), 1'b0, '0);
      end else if (pick < 93) begin
        send_item(OP_UNUSED, 8'($urandom), 4'($urandom), 1'b0, '0);
      end else begin
        repeat ($urandom_range(1, 6)) begin
          send_item(OP_CORPUS, 8'($urandom), 4'($urandom), 1'b0, '0);
        end
      end
    end
  endtask

  initial begin
    in_valid_i       <= 1'b0;
    op_i             <= OP_LOAD;
    byte_value_i     <= '0;
    needle_index_i   <= '0;
    cfg_valid_i      <= 1'b0;
    cfg_needle_len_i <= LEN_RESET;
    rst_ni           <= 1'b0;
    error_count    = 0;
    items_sent     = 0;
    send_idle_pct  = 35;
    recv_stall_pct = 35;
    len_reg        = LEN_RESET;
    fill_level     = 0;
    hit_count      = '0;
    for (int i = 0; i < NEEDLE_MAX; i++) begin
      needle_mem[i] = '0;
      window_mem[i] = '0;
    end
    derive_anchors();

    add_item(OP_LOAD,   8'h00, 4'd0,  1'b1, 1'b0, 1'b0, 32'd0, 1'b0);
    add_item(OP_LOAD,   8'hFF, 4'd1,  1'b1, 1'b0, 1'b0, 32'd0, 1'b0);
    add_item(OP_LOAD,   8'h80, 4'd2,  1'b1, 1'b0, 1'b0, 32'd0, 1'b0);
    add_item(OP_LOAD,   8'h7F, 4'd3,  1'b1, 1'b0, 1'b0, 32'd0, 1'b0);
    add_item(OP_CORPUS, 8'h00, 4'd0,  1'b1, 1'b0, 1'b0, 32'd0, 1'b0);
    add_item(OP_CORPUS, 8'hFF, 4'd15, 1'b1, 1'b0, 1'b0, 32'd0, 1'b0);
    add_item(OP_CORPUS, 8'h80, 4'd0,  1'b1, 1'b0, 1'b0, 32'd0, 1'b0);
    add_item(OP_CORPUS, 8'h7F, 4'd0,  1'b1, 1'b1, 1'b1, 32'd1, 1'b0);
    add_item(OP_CORPUS, 8'h00, 4'd0,  1'b0, 1'b0, 1'b0, 32'd0, 1'b0);
    add_item(OP_UNUSED, 8'hAA, 4'd5,  1'b1, 1'b0, 1'b0, 32'd1, 1'b0);
    add_item(OP_LOAD,   8'h55, 4'd15, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0);
    add_item(OP_END,    8'hFF, 4'd15, 1'b1, 1'b0, 1'b0, 32'd1, 1'b1);
    add_item(OP_CORPUS, 8'h7F, 4'd0,  1'b1, 1'b0, 1'b0, 32'd0, 1'b0);
    add_len(5'd0);
    add_item(OP_CORPUS, 8'h00, 4'd0,  1'b0, 1'b0, 1'b0, 32'd0, 1'b0);
    add_item(OP_CORPUS, 8'h00, 4'd0,  1'b0, 1'b0, 1'b0, 32'd0, 1'b0);
    add_item(OP_CORPUS, 8'h01, 4'd0,  1'b0, 1'b0, 1'b0, 32'd0, 1'b0);
    add_len(5'd1);
    add_item(OP_CORPUS, 8'h00, 4'd0,  1'b0, 1'b0, 1'b0, 32'd0, 1'b0);
    add_len(LEN_RESET);
    add_item(OP_CORPUS, 8'hFF, 4'd0,  1'b0, 1'b0, 1'b0, 32'd0, 1'b0);
    add_item(OP_CORPUS, 8'h80, 4'd0,  1'b0, 1'b0, 1'b0, 32'd0, 1'b0);
    add_item(OP_CORPUS, 8'h7F, 4'd0,  1'b0, 1'b0, 1'b0, 32'd0, 1'b0);
    add_item(OP_END,    8'h00, 4'd0,  1'b0, 1'b0, 1'b0, 32'd0, 1'b0);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        write_len(plan[i].len);
      end else begin
        send_item(plan[i].op, plan[i].data, plan[i].idx, plan[i].typed, plan[i].res);
      end
    end

    for (int ph = 0; ph < 8; ph++) begin
      run_phase(ph, (ph == 7) ? 5'($urandom) : PHASE_LEN[ph]);
    end

    in_valid_i <= 1'b0;
    while (pending.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    match_res_t got;
    match_res_t want;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        got = {anchors_agree_o, match_here_o, occurrences_o, done_res_o};
        if (pending.size() == 0) begin
          error_count++;
          if (error_count <= 10) begin
            $display("Unexpected result transaction: agree=%0b hit=%0b count=%0d done=%0b",
                     got.anchors_ok, got.full_hit, got.count, got.done);
          end
        end else begin
          want = pending.pop_front();
          if (got !== want) begin
            error_count++;
            if (error_count <= 10) begin
              $display("Mismatch: expected agree=%0b hit=%0b count=%0d done=%0b",
                       want.anchors_ok, want.full_hit, want.count, want.done);
              $display("          actual   agree=%0b hit=%0b count=%0d done=%0b",
                       got.anchors_ok, got.full_hit, got.count, got.done);
            end
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
